[rtl/sme_pkg.sv]
// Shared types, codes and fixed-point helpers for the stack machine executor.
package sme_pkg;

    localparam int DATA_W            = 32;
    localparam int DEPTH_W           = 7;
    localparam int STACK_DEPTH_DEF   = 64;
    localparam int FRAC_BITS_DEF     = 16;

    // Opcodes
    localparam logic [2:0] OP_PUSH  = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;
    localparam logic [2:0] OP_OUT   = 3'd5;
    localparam logic [2:0] OP_HALT  = 3'd6;

    // Status codes
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_HALT  = 3'd1;
    localparam logic [2:0] ST_UNDER = 3'd2;
    localparam logic [2:0] ST_OVER  = 3'd3;
    localparam logic [2:0] ST_BADOP = 3'd4;
    localparam logic [2:0] ST_DIVZ  = 3'd5;
    localparam logic [2:0] ST_STOP  = 3'd6;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [2:0]               action;
        logic signed [DATA_W-1:0] immediate;
    } cmd_t;

    typedef struct packed {
        logic [2:0]               status;
        logic                     out_valid;
        logic signed [DATA_W-1:0] out_value;
        logic [DEPTH_W-1:0]       depth_now;
    } rsp_t;

    // Magnitude of a two's complement word; the most negative value maps to 2^31.
    function automatic logic [DATA_W-1:0] q_mag(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] m;
        m = v[DATA_W-1] ? (~v + 32'd1) : v;
        return m;
    endfunction

    // Apply a sign to a magnitude and saturate to the 32-bit signed range.
    function automatic logic [DATA_W-1:0] q_sat(input logic [63:0] mag, input logic neg);
        logic [DATA_W-1:0] r;
        if (neg)
        begin
            if (mag >= 64'h0000_0000_8000_0000)
                r = Q_MIN;
            else
                r = ~mag[DATA_W-1:0] + 32'd1;
        end
        else
        begin
            if (mag > 64'h0000_0000_7FFF_FFFF)
                r = Q_MAX;
            else
                r = mag[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/stack_machine_executor_top.sv]
// Stack machine executor top level: sequencer around the stack memory and divider.
//
// Executes one stack-machine instruction per command transaction and returns exactly
// one response transaction for it. Operands are signed fixed point with FRAC_BITS
// fraction bits. The operand stack lives in a single-port-read, single-port-write
// synchronous memory with registered read data, so every pop costs a memory read
// and the sequencer takes one instruction at a time. Push, halt, bad opcode,
// underflow on an empty stack and any command to a stopped machine complete in
// decode; out completes after one pop; add and sub after two pops; mul pops two,
// registers a 32x32 magnitude product, then shifts and saturates; div pops two and,
// unless the divisor is zero, runs the restoring divider, which produces one quotient
// bit per cycle. The response appears in the output register the cycle after the
// instruction completes, and a new command is taken while a response still waits
// there; the sequencer only stalls when a second response is ready before the first
// one is taken. The stack memory needs no clearing after reset: only entries below
// the stack count are ever read.
module stack_machine_executor_top import sme_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W  = DATA_W + FRAC_BITS;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_POP_A  = 3'd2;
    localparam logic [2:0] S_POP_B  = 3'd3;
    localparam logic [2:0] S_MUL    = 3'd4;
    localparam logic [2:0] S_SAT    = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;

    logic [2:0]        state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              stopped_reg, stopped_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg,     rsp_next;
    logic [2:0]        op_reg,      op_next;
    logic [DATA_W-1:0] imm_reg,     imm_next;
    logic [DATA_W-1:0] a_reg,       a_next;
    logic [DATA_W-1:0] b_reg,       b_next;
    logic [63:0]       prod_reg,    prod_next;

    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  count_m2;
    logic              can_emit;
    logic              emit;
    logic [2:0]        res_status;
    logic              res_out_valid;
    logic [DATA_W-1:0] res_out_value;
    logic              res_neg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic [DATA_W-1:0] div_den;
    logic              div_busy;
    logic [NUM_W-1:0]  div_quot;

    sme_stack_ram #(
        .STACK_DEPTH (STACK_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sme_divider #(
        .NUM_W (NUM_W)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    assign count_m1  = count_reg - 1'b1;
    assign count_m2  = count_reg - 2'd2;
    // The response register is free, or frees up at this edge.
    assign can_emit  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_IDLE);

    // Divider operands: |B| scaled by the fraction bits over |A|.
    assign div_num = NUM_W'(q_mag(mem_rdata)) << FRAC_BITS;
    assign div_den = q_mag(a_reg);
    assign res_neg = a_reg[DATA_W-1] ^ b_reg[DATA_W-1];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        stopped_next  = stopped_reg;
        op_next       = op_reg;
        imm_next      = imm_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        prod_next     = prod_reg;
        emit          = 1'b0;
        res_status    = ST_OK;
        res_out_valid = 1'b0;
        res_out_value = '0;
        mem_we        = 1'b0;
        mem_waddr     = count_m2[ADDR_W-1:0];
        mem_wdata     = imm_reg;
        mem_re        = 1'b0;
        mem_raddr     = count_m1[ADDR_W-1:0];
        div_start     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                // Latch the command transaction.
                if (cmd_valid)
                begin
                    op_next    = cmd.action;
                    imm_next   = cmd.immediate;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (stopped_reg)
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        res_status = ST_STOP;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    case (op_reg)
                        OP_PUSH:
                        begin
                            if (can_emit)
                            begin
                                emit       = 1'b1;
                                state_next = S_IDLE;
                                if (count_reg >= CNT_W'(STACK_DEPTH))
                                begin
                                    res_status   = ST_OVER;
                                    stopped_next = 1'b1;
                                end
                                else
                                begin
                                    mem_we     = 1'b1;
                                    mem_waddr  = count_reg[ADDR_W-1:0];
                                    mem_wdata  = imm_reg;
                                    count_next = count_reg + 1'b1;
                                end
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_OUT:
                        begin
                            if (count_reg == '0)
                            begin
                                if (can_emit)
                                begin
                                    emit         = 1'b1;
                                    res_status   = ST_UNDER;
                                    stopped_next = 1'b1;
                                    state_next   = S_IDLE;
                                end
                            end
                            else
                            begin
                                // Fetch the top entry.
                                mem_re     = 1'b1;
                                mem_raddr  = count_m1[ADDR_W-1:0];
                                state_next = S_POP_A;
                            end
                        end
                        OP_HALT:
                        begin
                            if (can_emit)
                            begin
                                emit         = 1'b1;
                                res_status   = ST_HALT;
                                stopped_next = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                        default:
                        begin
                            if (can_emit)
                            begin
                                emit         = 1'b1;
                                res_status   = ST_BADOP;
                                stopped_next = 1'b1;
                                state_next   = S_IDLE;
                            end
                        end
                    endcase
                end
            end

            S_POP_A:
            begin
                if (op_reg == OP_OUT)
                begin
                    if (can_emit)
                    begin
                        emit          = 1'b1;
                        res_out_valid = 1'b1;
                        res_out_value = mem_rdata;
                        count_next    = count_m1;
                        state_next    = S_IDLE;
                    end
                end
                else if (count_reg == CNT_W'(1))
                begin
                    // Second operand missing: the first pop stays done.
                    if (can_emit)
                    begin
                        emit         = 1'b1;
                        res_status   = ST_UNDER;
                        stopped_next = 1'b1;
                        count_next   = '0;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    a_next     = mem_rdata;
                    mem_re     = 1'b1;
                    mem_raddr  = count_m2[ADDR_W-1:0];
                    state_next = S_POP_B;
                end
            end

            S_POP_B:
            begin
                b_next = mem_rdata;
                if (op_reg inside {OP_ADD, OP_SUB})
                begin
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        mem_we     = 1'b1;
                        mem_wdata  = (op_reg == OP_ADD) ? (mem_rdata + a_reg)
                                                        : (mem_rdata - a_reg);
                        count_next = count_m1;
                        state_next = S_IDLE;
                    end
                end
                else if (op_reg == OP_MUL)
                begin
                    state_next = S_MUL;
                end
                else if (a_reg == '0)
                begin
                    // Divide by zero: saturate toward the sign of B, keep running.
                    if (can_emit)
                    begin
                        emit       = 1'b1;
                        res_status = ST_DIVZ;
                        mem_we     = 1'b1;
                        if (mem_rdata == '0)
                            mem_wdata = '0;
                        else if (mem_rdata[DATA_W-1])
                            mem_wdata = Q_MIN;
                        else
                            mem_wdata = Q_MAX;
                        count_next = count_m1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end

            S_MUL:
            begin
                prod_next  = 64'(q_mag(a_reg)) * 64'(q_mag(b_reg));
                state_next = S_SAT;
            end

            S_SAT:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = q_sat(prod_reg >> FRAC_BITS, res_neg);
                    count_next = count_m1;
                    state_next = S_IDLE;
                end
            end

            S_DIV:
            begin
                if (!div_busy && can_emit)
                begin
                    emit       = 1'b1;
                    mem_we     = 1'b1;
                    mem_wdata  = q_sat(64'(div_quot), res_neg);
                    count_next = count_m1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Response register: load on completion, drop once taken.
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (emit)
        begin
            rsp_next.status    = res_status;
            rsp_next.out_valid = res_out_valid;
            rsp_next.out_value = res_out_value;
            rsp_next.depth_now = DEPTH_W'(count_next);
            rsp_valid_next     = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            stopped_reg   <= stopped_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        op_reg   <= op_next;
        imm_reg  <= imm_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/sme_stack_ram.sv]
// Operand stack storage: one write port, one read port with registered read data.
module sme_stack_ram import sme_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sme_divider.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module sme_divider import sme_pkg::*; #(
    parameter int NUM_W = DATA_W + FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DATA_W-1:0] den,
    output logic              busy,
    output logic [NUM_W-1:0]  quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [NUM_W-1:0]  quot_reg, quot_next;
    logic [DATA_W-1:0] rem_reg,  rem_next;
    logic [DATA_W-1:0] den_reg,  den_next;
    logic [DATA_W:0]   trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quot_reg[NUM_W-1]};
        if (start)
        begin
            cnt_next  = CNT_W'(NUM_W);
            quot_next = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (cnt_reg != '0)
        begin
            // Shift the next dividend bit in; subtract when the divisor fits.
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = DATA_W'(trial - {1'b0, den_reg});
                quot_next = {quot_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DATA_W-1:0];
                quot_next = {quot_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = quot_reg;

endmodule
